// File: rtl/core/fixed_block_pool_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block pool allocator
// Shared property wrappers used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define FBPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fixed_block_pool_allocator: same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fixed_block_pool_allocator: next-cycle check failed");

`endif

// File: rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types and constants shared by the block pool allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned OFFSET_W = 22;
	localparam int unsigned CAP_W    = 11;
	localparam int unsigned BBYTES_W = 13;
	localparam int unsigned KIND_W   = 2;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W  = 1;

	localparam logic [CAP_W-1:0]    CAP_RESET    = 11'd1024;
	localparam logic [BBYTES_W-1:0] BBYTES_RESET = 13'd8;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CAPACITY    = 1'b0,
		REG_BLOCK_BYTES = 1'b1
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_TAKE = 2'd0,
		KIND_GIVE = 2'd1,
		KIND_WIPE = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	typedef struct packed {
		logic [CAP_W-1:0]    capacity;
		logic [BBYTES_W-1:0] block_bytes;
	} cfg_t;

endpackage

// File: rtl/core/fbpa_link_mem.sv
// ----------------------------------------------------------------------------
// fbpa_link_mem
// Free-list link memory: one entry per slot holding the next free slot and
// a flag that marks whether that next slot exists. One write port, one read
// port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_link_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned IW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [IW:0]   wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output logic [IW:0]   rdata
);

	logic [IW:0] mem [DEPTH];
	logic [IW:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: holds the free-list head and the bump counter, drives
// the link memory, and forms each response in an output register.
// ----------------------------------------------------------------------------
module fbpa_ctrl #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned IW    = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fbpa_pkg::cfg_t                      cfg,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [fbpa_pkg::KIND_W-1:0]         kind,
	input  logic [fbpa_pkg::SLOT_W-1:0]         slot,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [fbpa_pkg::SLOT_W-1:0]         granted_slot,
	output logic [fbpa_pkg::OFFSET_W-1:0]       byte_offset,
	output logic                                ok,
	output logic                                mem_we,
	output logic [IW-1:0]                       mem_waddr,
	output logic [IW:0]                         mem_wdata,
	output logic                                mem_re,
	output logic [IW-1:0]                       mem_raddr,
	input  logic [IW:0]                         mem_rdata
);

	localparam int unsigned SW  = (IW + 1 > fbpa_pkg::SLOT_W) ? IW + 1 : fbpa_pkg::SLOT_W;
	localparam int unsigned CMW = (IW + 1 > fbpa_pkg::CAP_W) ? IW + 1 : fbpa_pkg::CAP_W;
	localparam int unsigned PW  = IW + fbpa_pkg::BBYTES_W;

	fbpa_pkg::state_t state_q, state_d;
	logic [IW-1:0] head_q, head_d;
	logic          head_valid_q, head_valid_d;
	logic [IW:0]   bump_q, bump_d;

	logic                            rsp_valid_q;
	logic [fbpa_pkg::SLOT_W-1:0]     granted_q;
	logic [fbpa_pkg::OFFSET_W-1:0]   offset_q;
	logic                            ok_q;

	logic          accept;
	logic [SW-1:0] slot_ext;
	logic          slot_in_range;
	logic [IW-1:0] slot_idx;
	logic [CMW-1:0] cap_ext;
	logic [CMW-1:0] cap_eff;
	logic [CMW-1:0] bump_ext;
	logic          bump_room;

	logic [IW-1:0] grant_idx;
	logic          grant_ok;
	logic [PW-1:0] product;

	assign req_stall = (state_q != fbpa_pkg::ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	assign slot_ext      = SW'(slot);
	assign slot_in_range = slot_ext < SW'(DEPTH);
	assign slot_idx      = slot_ext[IW-1:0];

	// The capacity in effect never exceeds the built depth.
	assign cap_ext   = CMW'(cfg.capacity);
	assign cap_eff   = (cap_ext > CMW'(DEPTH)) ? CMW'(DEPTH) : cap_ext;
	assign bump_ext  = CMW'(bump_q);
	assign bump_room = bump_ext < cap_eff;

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		head_valid_d = head_valid_q;
		bump_d       = bump_q;
		mem_we       = 1'b0;
		mem_waddr    = slot_idx;
		mem_wdata    = {head_valid_q, head_q};
		mem_re       = 1'b0;
		mem_raddr    = head_q;
		grant_idx    = '0;
		grant_ok     = 1'b0;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						fbpa_pkg::KIND_TAKE: begin
							if (head_valid_q) begin
								// The granted slot is the head itself; its link is
								// fetched now and is loaded as the new head in the pop state.
								grant_idx = head_q;
								grant_ok  = 1'b1;
								mem_re    = 1'b1;
								state_d   = fbpa_pkg::ST_POP;
							end else if (bump_room) begin
								grant_idx = bump_q[IW-1:0];
								grant_ok  = 1'b1;
								bump_d    = bump_q + 1'b1;
							end
						end
						fbpa_pkg::KIND_GIVE: begin
							if (slot_in_range) begin
								mem_we       = 1'b1;
								head_d       = slot_idx;
								head_valid_d = 1'b1;
							end
						end
						fbpa_pkg::KIND_WIPE: begin
							head_d       = '0;
							head_valid_d = 1'b0;
							bump_d       = '0;
						end
						default: begin
						end
					endcase
				end
			end
			fbpa_pkg::ST_POP: begin
				head_d       = mem_rdata[IW-1:0];
				head_valid_d = mem_rdata[IW];
				state_d      = fbpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = fbpa_pkg::ST_IDLE;
			end
		endcase
	end

	assign product = PW'(grant_idx) * PW'(cfg.block_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fbpa_pkg::ST_IDLE;
			head_q       <= '0;
			head_valid_q <= 1'b0;
			bump_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			head_valid_q <= head_valid_d;
			bump_q       <= bump_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			granted_q <= fbpa_pkg::SLOT_W'(grant_idx);
			offset_q  <= product[fbpa_pkg::OFFSET_W-1:0];
			unique case (kind)
				fbpa_pkg::KIND_TAKE: ok_q <= grant_ok;
				fbpa_pkg::KIND_GIVE: ok_q <= slot_in_range;
				fbpa_pkg::KIND_WIPE: ok_q <= 1'b1;
				default:             ok_q <= 1'b0;
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign granted_slot = granted_q;
	assign byte_offset  = offset_q;
	assign ok           = ok_q;

endmodule

// File: rtl/core/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Equal-size block allocator with a LIFO free list held in a link memory.
// ----------------------------------------------------------------------------
// Each request gives exactly one response. A give, a wipe, a take served
// from the bump counter and a failed take are done in the idle state; a
// take served from the free list also holds the block in the pop state,
// as the popped slot's link must come back from the registered read port
// of the link memory before it becomes the new head. Responses sit in an
// output register, so a new request is taken while an earlier response
// still waits unless it is being stalled. The link memory needs no clearing
// after reset: an entry is only ever read after a give has written it.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fbpa_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [fbpa_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [fbpa_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [fbpa_pkg::KIND_W-1:0]         kind,
	input  logic [fbpa_pkg::SLOT_W-1:0]         slot,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [fbpa_pkg::SLOT_W-1:0]         granted_slot,
	output logic [fbpa_pkg::OFFSET_W-1:0]       byte_offset,
	output logic                                ok
);

	localparam int unsigned IW = $clog2(DEPTH);

	fbpa_pkg::cfg_t cfg_q;
	logic           cfg_wr;
	logic [fbpa_pkg::REG_IDX_W-1:0] reg_idx;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [IW:0]   mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic [IW:0]   mem_rdata;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[fbpa_pkg::APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity    <= fbpa_pkg::CAP_RESET;
			cfg_q.block_bytes <= fbpa_pkg::BBYTES_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				fbpa_pkg::REG_CAPACITY:
					cfg_q.capacity <= pwdata[fbpa_pkg::CAP_W-1:0];
				fbpa_pkg::REG_BLOCK_BYTES:
					cfg_q.block_bytes <= pwdata[fbpa_pkg::BBYTES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			fbpa_pkg::REG_CAPACITY:
				prdata = fbpa_pkg::APB_DATA_W'(cfg_q.capacity);
			fbpa_pkg::REG_BLOCK_BYTES:
				prdata = fbpa_pkg::APB_DATA_W'(cfg_q.block_bytes);
			default:
				prdata = '0;
		endcase
	end

	fbpa_ctrl #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.slot         (slot),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.granted_slot (granted_slot),
		.byte_offset  (byte_offset),
		.ok           (ok),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	fbpa_link_mem #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// While a popped link is in flight, no new request may slip in.
	`FBPA_ASSERT_NEXT(a_pop_interlock, clk, arst_n, mem_re, req_stall)
	// A push and a pop never touch the link memory in the same cycle.
	`FBPA_ASSERT_SAME(a_mem_one_access, clk, arst_n, mem_we, !mem_re)
	// Every accepted request leaves a response in the output register.
	`FBPA_ASSERT_NEXT(a_rsp_follows, clk, arst_n, req_valid && !req_stall, rsp_valid)

endmodule
